### src/aef_pkg.sv
package aef_pkg;

    // Widths of the fixed-point quantities.
    localparam int unsigned GAIN_W   = 16;
    localparam int unsigned COEF_W   = 25;
    localparam int unsigned SAMPLE_W = 16;
    localparam int unsigned ENV_W    = 25;
    localparam int unsigned LEVEL_W  = 28;
    localparam int unsigned OUT_W    = 19;
    localparam int unsigned OUT_TDATA_W = 24;
    localparam int unsigned IDX_W    = 3;

    typedef logic [COEF_W-1:0] t_coef;
    typedef logic [GAIN_W-1:0] t_gain;

    // Configuration register indexes.
    localparam logic [IDX_W-1:0] REG_IN_GAIN        = 3'd0;
    localparam logic [IDX_W-1:0] REG_OUT_GAIN       = 3'd1;
    localparam logic [IDX_W-1:0] REG_RISE_THRESHOLD = 3'd2;
    localparam logic [IDX_W-1:0] REG_ATTACK_COEF    = 3'd3;
    localparam logic [IDX_W-1:0] REG_RELEASE_COEF   = 3'd4;
    localparam logic [IDX_W-1:0] REG_AVERAGE_COEF   = 3'd5;

    // Input word kinds carried on tuser.
    localparam logic CMD_PROCESS = 1'b0;
    localparam logic CMD_CLEAR   = 1'b1;

    // Reset values of the registers.
    localparam t_gain RST_IN_GAIN        = 16'd4096;
    localparam t_gain RST_OUT_GAIN       = 16'd4096;
    localparam logic [15:0] RST_RISE_THRESHOLD = 16'd0;
    localparam t_coef RST_ATTACK_COEF    = 25'd152177;
    localparam t_coef RST_RELEASE_COEF   = 25'd6087;
    localparam t_coef RST_AVERAGE_COEF   = 25'd380;

    localparam logic [ENV_W-1:0]   ENV_ONE    = 25'd16777216;
    localparam logic [LEVEL_W-1:0] CLIP_LEVEL = 28'd16609444;
    localparam logic [OUT_W-1:0]   OUT_MAX    = 19'd524287;

    // Coefficients above 1.0 are used as exactly 1.0.
    function automatic t_coef clamp_coef(input t_coef c);
        t_coef res;
        res = (c[COEF_W-1] && (|c[COEF_W-2:0])) ? ENV_ONE : c;
        return res;
    endfunction

endpackage

### src/audio_envelope_follower_unit.sv
// Each sample word, once accepted, passes through one sequencer step each
// for level, average, decision, envelope and output gain, the output step
// loading the output register; a clipping sample skips the envelope step,
// and a clear word goes straight to the output step.
// The block takes one word at a time: a new word is accepted only in the idle
// state, after the output step of the last word, which waits on any output stall.
// Reset is synchronous and active low: it restores the register defaults,
// zeroes envelope and running average, and empties the output register.
module audio_envelope_follower_unit
    import aef_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // Configuration write channel.
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [IDX_W-1:0]       i_cfg_index,
    input  logic [COEF_W-1:0]      i_cfg_data,
    // Input stream.
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [SAMPLE_W-1:0]    s_axis_tdata,  // [15:0] sample
    input  logic                   s_axis_tuser,  // [0] cmd
    // Output stream.
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata   // [18:0] envelope_out, [23:19] zero
);

    // Sequencer states.
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_LEVEL = 3'd1;
    localparam logic [2:0] ST_AVG   = 3'd2;
    localparam logic [2:0] ST_CMP   = 3'd3;
    localparam logic [2:0] ST_ENV   = 3'd4;
    localparam logic [2:0] ST_OUT   = 3'd5;

    localparam int unsigned MA_W = 26;
    localparam int unsigned MB_W = 30;
    localparam int unsigned MP_W = MA_W + MB_W;

    logic [2:0]          r_state;
    t_gain               r_in_gain;
    t_gain               r_out_gain;
    logic [15:0]         r_thr;
    t_coef               r_attack;
    t_coef               r_release;
    t_coef               r_average;

    logic [ENV_W-1:0]    r_env;
    logic [LEVEL_W-1:0]  r_avg;
    logic [LEVEL_W-1:0]  r_level;
    logic [SAMPLE_W:0]   r_mag;
    logic                r_attack_sel;

    logic                r_out_valid;
    logic [OUT_W-1:0]    r_out_data;

    logic signed [MA_W-1:0] w_ma;
    logic signed [MB_W-1:0] w_mb;
    logic signed [MP_W-1:0] w_prod;
    logic signed [31:0]     w_delta;
    logic signed [31:0]     w_avg_thr;
    logic                   w_accept;
    logic                   w_out_free;
    logic [SAMPLE_W:0]      w_mag;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_out_free    = !r_out_valid || m_axis_tready;

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(OUT_TDATA_W-OUT_W){1'b0}}, r_out_data};

    // Magnitude of the sample; the most negative code maps to exactly 1.0.
    assign w_mag = s_axis_tdata[SAMPLE_W-1]
                 ? (SAMPLE_W+1)'(-$signed({s_axis_tdata[SAMPLE_W-1], s_axis_tdata}))
                 : {1'b0, s_axis_tdata};

    // Operand selection for the shared multiplier. Each step but the decision step uses it once.
    always_comb begin
        w_ma = '0;
        w_mb = '0;
        case (r_state)
            ST_LEVEL: begin
                w_ma = $signed(MA_W'(r_mag));
                w_mb = $signed(MB_W'(r_in_gain));
            end
            ST_AVG: begin
                w_ma = $signed(MA_W'(clamp_coef(r_average)));
                w_mb = $signed(MB_W'(r_level)) - $signed(MB_W'(r_avg));
            end
            ST_ENV: begin
                if (r_attack_sel) begin
                    w_ma = $signed(MA_W'(clamp_coef(r_attack)));
                    w_mb = $signed(MB_W'(r_level)) - $signed(MB_W'(r_env));
                end else begin
                    w_ma = $signed(MA_W'(clamp_coef(r_release)));
                    w_mb = $signed(MB_W'(r_env));
                end
            end
            ST_OUT: begin
                w_ma = $signed(MA_W'(r_env));
                w_mb = $signed(MB_W'(r_out_gain));
            end
            default: begin
                w_ma = '0;
                w_mb = '0;
            end
        endcase
    end

    assign w_prod  = w_ma * w_mb;
    // Arithmetic shift by 24 is the floor of the Q0.24 product.
    assign w_delta = w_prod[55:24];
    // Average plus threshold, the threshold moved from Q1.15 to Q.24.
    assign w_avg_thr = $signed({4'b0, r_avg}) + $signed({{7{r_thr[15]}}, r_thr, 9'b0});

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_gain  <= RST_IN_GAIN;
            r_out_gain <= RST_OUT_GAIN;
            r_thr      <= RST_RISE_THRESHOLD;
            r_attack   <= RST_ATTACK_COEF;
            r_release  <= RST_RELEASE_COEF;
            r_average  <= RST_AVERAGE_COEF;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_IN_GAIN:        r_in_gain  <= i_cfg_data[GAIN_W-1:0];
                REG_OUT_GAIN:       r_out_gain <= i_cfg_data[GAIN_W-1:0];
                REG_RISE_THRESHOLD: r_thr      <= i_cfg_data[15:0];
                REG_ATTACK_COEF:    r_attack   <= i_cfg_data;
                REG_RELEASE_COEF:   r_release  <= i_cfg_data;
                REG_AVERAGE_COEF:   r_average  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Sequencer and datapath state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_env        <= '0;
            r_avg        <= '0;
            r_out_valid  <= 1'b0;
            r_attack_sel <= 1'b0;
        end else begin
            // The output step sets valid itself when it loads a new word.
            if (r_out_valid && m_axis_tready && (r_state != ST_OUT)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        if (s_axis_tuser == CMD_CLEAR) begin
                            r_env   <= '0;
                            r_state <= ST_OUT;
                        end else begin
                            r_mag   <= w_mag;
                            r_state <= ST_LEVEL;
                        end
                    end
                end
                ST_LEVEL: begin
                    // Level is Q.24, saturated just under 16.0.
                    r_level <= (|w_prod[32:31]) ? {LEVEL_W{1'b1}} : w_prod[30:3];
                    r_state <= ST_AVG;
                end
                ST_AVG: begin
                    r_avg   <= LEVEL_W'($signed({4'b0, r_avg}) + w_delta);
                    r_state <= ST_CMP;
                end
                ST_CMP: begin
                    if (r_level >= CLIP_LEVEL) begin
                        // Clip indication: envelope jumps to full scale.
                        r_env   <= ENV_ONE;
                        r_state <= ST_OUT;
                    end else begin
                        r_attack_sel <= ($signed({4'b0, r_level}) >= w_avg_thr);
                        r_state      <= ST_ENV;
                    end
                end
                ST_ENV: begin
                    if (r_attack_sel) begin
                        r_env <= ENV_W'($signed({7'b0, r_env}) + w_delta);
                    end else begin
                        r_env <= ENV_W'($signed({7'b0, r_env}) - w_delta);
                    end
                    r_state <= ST_OUT;
                end
                ST_OUT: begin
                    // Wait here until the output register can take the word.
                    if (w_out_free) begin
                        r_out_data  <= (|w_prod[MP_W-1:40]) ? OUT_MAX : w_prod[39:21];
                        r_out_valid <= 1'b1;
                        r_state     <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

endmodule

### src/aef_checker.sv
module aef_checker
    import aef_pkg::*;
(
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   s_axis_tvalid,
    input logic                   s_axis_tready,
    input logic                   s_axis_tuser,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    // The output is empty straight after reset.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output word present after reset");

    // A stalled output word holds its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled output word changed");

    // The block is busy in the cycle after it takes a word.
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input ready straight after acceptance");

    // A clear into an empty output gives a zero word, loaded by the output step into the output register.
    a_clear_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && (s_axis_tuser == CMD_CLEAR) && !m_axis_tvalid
        |-> ##2 m_axis_tvalid && (m_axis_tdata == '0))
        else $error("clear did not yield a zero envelope");

    // Padding bits above the envelope are always zero.
    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[OUT_TDATA_W-1:OUT_W] == '0))
        else $error("output padding bits set");

endmodule

bind audio_envelope_follower_unit aef_checker u_aef_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
